// ----- design/grd_pkg.sv -----
// Shared types and constants of the 2:1 grid restriction block.
`timescale 1ns / 1ps
`default_nettype none

package grd_pkg;

    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 11;
    localparam int FINE_CFG_BITS   = 11;
    localparam int COARSE_CFG_BITS = 10;
    localparam int GUARD_BITS      = 6;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FINE_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FINE_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COARSE_WIDTH  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COARSE_HEIGHT = 2'd3;

    localparam logic [FINE_CFG_BITS-1:0]   FINE_SIZE_RESET   = 11'd1024;
    localparam logic [COARSE_CFG_BITS-1:0] COARSE_SIZE_RESET = 10'd512;

    typedef struct packed {
        logic [FINE_CFG_BITS-1:0]   fine_width;
        logic [FINE_CFG_BITS-1:0]   fine_height;
        logic [COARSE_CFG_BITS-1:0] coarse_width;
        logic [COARSE_CFG_BITS-1:0] coarse_height;
    } cfg_regs_t;

    typedef enum logic [2:0] {
        VOP_STAG,
        VOP_EVEN_FIRST,
        VOP_EVEN,
        VOP_ODD,
        VOP_ODD_LAST
    } vop_t;

    typedef struct packed {
        logic valid;
        vop_t op;
        logic emit;
        logic last;
    } vctl_t;

    localparam vctl_t VCTL_IDLE = '{valid: 1'b0, op: VOP_STAG, emit: 1'b0, last: 1'b0};

endpackage

`default_nettype wire

// ----- design/grd_config.sv -----
// Configuration register file for the grid restriction block.
`timescale 1ns / 1ps
`default_nettype none

module grd_config
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [grd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [grd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output grd_pkg::cfg_regs_t                        cfg
);

    grd_pkg::cfg_regs_t cfg_reg;
    grd_pkg::cfg_regs_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                grd_pkg::REG_FINE_WIDTH:
                    cfg_next.fine_width = cfg_data[grd_pkg::FINE_CFG_BITS-1:0];
                grd_pkg::REG_FINE_HEIGHT:
                    cfg_next.fine_height = cfg_data[grd_pkg::FINE_CFG_BITS-1:0];
                grd_pkg::REG_COARSE_WIDTH:
                    cfg_next.coarse_width = cfg_data[grd_pkg::COARSE_CFG_BITS-1:0];
                grd_pkg::REG_COARSE_HEIGHT:
                    cfg_next.coarse_height = cfg_data[grd_pkg::COARSE_CFG_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fine_width    <= grd_pkg::FINE_SIZE_RESET;
            cfg_reg.fine_height   <= grd_pkg::FINE_SIZE_RESET;
            cfg_reg.coarse_width  <= grd_pkg::COARSE_SIZE_RESET;
            cfg_reg.coarse_height <= grd_pkg::COARSE_SIZE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/grd_col_pass.sv -----
// Raster position tracking and horizontal restriction pass.
`timescale 1ns / 1ps
`default_nettype none

module grd_col_pass
#(
    parameter int MAX_FINE_WIDTH  = 1024,
    parameter int MAX_FINE_HEIGHT = 1024,
    parameter int SAMPLE_BITS     = 16
)
(
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire grd_pkg::cfg_regs_t                           cfg,
    input  wire logic                                         fine_valid,
    input  wire logic [SAMPLE_BITS-1:0]                       fine_sample,
    input  wire logic                                         frame_start,
    input  wire logic                                         en,
    output grd_pkg::vctl_t                                    ctl_out,
    output logic [SAMPLE_BITS+grd_pkg::GUARD_BITS-1:0]        h_out,
    output logic [$clog2(MAX_FINE_WIDTH/2+1)-1:0]             hc_out
);

    localparam int W   = SAMPLE_BITS + grd_pkg::GUARD_BITS;
    localparam int AW  = $clog2(MAX_FINE_WIDTH / 2 + 1);
    localparam int XW  = $clog2(MAX_FINE_WIDTH);
    localparam int YW  = $clog2(MAX_FINE_HEIGHT);
    localparam int FW  = $clog2(MAX_FINE_WIDTH + 1);
    localparam int FH  = $clog2(MAX_FINE_HEIGHT + 1);
    localparam int CB  = grd_pkg::COARSE_CFG_BITS;

    logic [FW-1:0] fw;
    logic [FH-1:0] fh;
    logic [CB-1:0] cw_raw;
    logic [CB-1:0] ch_raw;
    logic [CB-1:0] cw;
    logic [CB-1:0] ch;
    logic          hcen;
    logic          vcen;
    logic [31:0]   w_half;
    logic [31:0]   h_half;

    logic [XW-1:0] col_reg;
    logic [XW-1:0] col_next;
    logic [YW-1:0] row_reg;
    logic [YW-1:0] row_next;
    logic [W-1:0]  cp0_reg;
    logic [W-1:0]  cp0_next;
    logic [W-1:0]  cp1_reg;
    logic [W-1:0]  cp1_next;

    logic [XW-1:0] col_cur;
    logic [YW-1:0] row_cur;
    logic          wrap_col;
    logic [31:0]   row_t;
    logic [31:0]   col_adv;
    logic [31:0]   row_adv;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic [XW-1:0] i;
    logic [YW-1:0] j;
    logic [W-1:0]  s_ext;
    logic [W-1:0]  s3;
    logic [W-1:0]  t3;
    logic          have_h;
    logic [W-1:0]  h;
    logic [AW-1:0] hc;
    logic          vis;
    logic          row_last;
    logic          accept;

    grd_pkg::vctl_t ctl_next;
    grd_pkg::vctl_t s1_ctl_reg;
    logic [W-1:0]   s1_h_reg;
    logic [AW-1:0]  s1_hc_reg;

    assign accept  = fine_valid && en;
    assign ctl_out = s1_ctl_reg;
    assign h_out   = s1_h_reg;
    assign hc_out  = s1_hc_reg;

    always_comb
    begin
        if (cfg.fine_width == '0)
            fw = FW'(1);
        else if (32'(cfg.fine_width) > 32'(MAX_FINE_WIDTH))
            fw = FW'(MAX_FINE_WIDTH);
        else
            fw = FW'(cfg.fine_width);

        if (cfg.fine_height == '0)
            fh = FH'(1);
        else if (32'(cfg.fine_height) > 32'(MAX_FINE_HEIGHT))
            fh = FH'(MAX_FINE_HEIGHT);
        else
            fh = FH'(cfg.fine_height);

        cw_raw = (cfg.coarse_width == '0) ? CB'(1) : cfg.coarse_width;
        ch_raw = (cfg.coarse_height == '0) ? CB'(1) : cfg.coarse_height;
        hcen   = 32'(fw) == (32'(cw_raw) << 1);
        vcen   = 32'(fh) == (32'(ch_raw) << 1);
        w_half = (32'(fw) + 32'd1) >> 1;
        h_half = (32'(fh) + 32'd1) >> 1;
        cw     = (!hcen && 32'(cw_raw) > w_half) ? CB'(w_half) : cw_raw;
        ch     = (!vcen && 32'(ch_raw) > h_half) ? CB'(h_half) : ch_raw;
    end

    always_comb
    begin
        col_cur  = frame_start ? '0 : col_reg;
        row_cur  = frame_start ? '0 : row_reg;
        wrap_col = 32'(col_cur) >= 32'(fw);
        x        = wrap_col ? '0 : col_cur;
        row_t    = 32'(row_cur) + (wrap_col ? 32'd1 : 32'd0);
        y        = (row_t >= 32'(fh)) ? '0 : YW'(row_t);

        col_adv = 32'(x) + 32'd1;
        row_adv = 32'(y) + 32'd1;
        if (col_adv >= 32'(fw))
        begin
            col_next = '0;
            row_next = (row_adv >= 32'(fh)) ? '0 : YW'(row_adv);
        end
        else
        begin
            col_next = XW'(col_adv);
            row_next = y;
        end

        s_ext = {{grd_pkg::GUARD_BITS{fine_sample[SAMPLE_BITS-1]}}, fine_sample};
        s3    = (s_ext << 1) + s_ext;
        t3    = cp0_reg + s3;
        i     = x >> 1;

        cp0_next = cp0_reg;
        cp1_next = cp1_reg;
        have_h   = 1'b0;
        h        = s_ext << 3;
        hc       = AW'(i);

        if (hcen)
        begin
            if (!x[0])
            begin
                if (i != '0)
                begin
                    h      = cp0_reg + s_ext;
                    hc     = AW'(32'(i) - 32'd1);
                    have_h = 1'b1;
                end
                cp0_next = (i == '0) ? (s_ext << 2) : (cp1_reg + s3);
                cp1_next = '0;
            end
            else if (32'(i) + 32'd1 < 32'(cw))
            begin
                cp0_next = t3;
                cp1_next = s_ext;
            end
            else
            begin
                cp0_next = t3 + s_ext;
                h        = t3 + s_ext;
                have_h   = 1'b1;
            end
        end
        else if (!x[0] && 32'(i) < 32'(cw))
        begin
            have_h = 1'b1;
        end

        j        = y >> 1;
        ctl_next = grd_pkg::VCTL_IDLE;
        if (!vcen)
        begin
            ctl_next.op   = grd_pkg::VOP_STAG;
            vis           = !y[0] && (32'(j) < 32'(ch));
            ctl_next.emit = vis;
            row_last      = (32'(j) + 32'd1) == 32'(ch);
        end
        else if (!y[0])
        begin
            vis           = 1'b1;
            ctl_next.op   = (j == '0) ? grd_pkg::VOP_EVEN_FIRST : grd_pkg::VOP_EVEN;
            ctl_next.emit = j != '0;
            row_last      = 32'(j) == 32'(ch);
        end
        else
        begin
            vis           = 1'b1;
            ctl_next.emit = !((32'(j) + 32'd1) < 32'(ch));
            ctl_next.op   = ctl_next.emit ? grd_pkg::VOP_ODD_LAST : grd_pkg::VOP_ODD;
            row_last      = (32'(j) + 32'd1) == 32'(ch);
        end
        ctl_next.valid = accept && have_h && vis;
        ctl_next.last  = row_last && ((32'(hc) + 32'd1) == 32'(cw));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            cp0_reg    <= '0;
            cp1_reg    <= '0;
            s1_ctl_reg <= grd_pkg::VCTL_IDLE;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                cp0_reg <= cp0_next;
                cp1_reg <= cp1_next;
            end
            if (en)
            begin
                s1_ctl_reg <= ctl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_h_reg  <= h;
            s1_hc_reg <= hc;
        end
    end

endmodule

`default_nettype wire

// ----- design/grd_row_pass.sv -----
// Vertical restriction pass over the two row accumulator memories.
`timescale 1ns / 1ps
`default_nettype none

module grd_row_pass
#(
    parameter int MAX_FINE_WIDTH = 1024,
    parameter int SAMPLE_BITS    = 16
)
(
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     en,
    input  wire grd_pkg::vctl_t                           ctl_in,
    input  wire logic [SAMPLE_BITS+grd_pkg::GUARD_BITS-1:0] h_in,
    input  wire logic [$clog2(MAX_FINE_WIDTH/2+1)-1:0]    hc_in,
    output logic                                          res_valid,
    output logic [SAMPLE_BITS-1:0]                        res_sample,
    output logic                                          res_last
);

    localparam int W     = SAMPLE_BITS + grd_pkg::GUARD_BITS;
    localparam int DEPTH = MAX_FINE_WIDTH / 2 + 1;
    localparam int AW    = $clog2(DEPTH);

    logic [W-1:0] mem_even [DEPTH];
    logic [W-1:0] mem_odd  [DEPTH];

    logic [W-1:0]   rd_even_reg;
    logic [W-1:0]   rd_odd_reg;
    grd_pkg::vctl_t s2_ctl_reg;
    logic [W-1:0]   s2_h_reg;
    logic [AW-1:0]  s2_hc_reg;

    logic           fwd_even_valid_reg;
    logic [AW-1:0]  fwd_even_addr_reg;
    logic [W-1:0]   fwd_even_data_reg;
    logic           fwd_odd_valid_reg;
    logic [AW-1:0]  fwd_odd_addr_reg;
    logic [W-1:0]   fwd_odd_data_reg;

    logic [W-1:0] even_cur;
    logic [W-1:0] odd_cur;
    logic [W-1:0] h3;
    logic [W-1:0] acc;
    logic [W-1:0] rounded;
    logic [W-1:0] even_new;
    logic [W-1:0] odd_new;
    logic         we_even;
    logic         we_odd;

    always_comb
    begin
        even_cur = (fwd_even_valid_reg && fwd_even_addr_reg == s2_hc_reg)
                   ? fwd_even_data_reg : rd_even_reg;
        odd_cur  = (fwd_odd_valid_reg && fwd_odd_addr_reg == s2_hc_reg)
                   ? fwd_odd_data_reg : rd_odd_reg;
        h3       = (s2_h_reg << 1) + s2_h_reg;
        acc      = s2_h_reg << 3;
        even_new = even_cur;
        odd_new  = s2_h_reg;
        we_even  = 1'b0;
        we_odd   = 1'b0;

        case (s2_ctl_reg.op)
            grd_pkg::VOP_STAG:
            begin
                acc = s2_h_reg << 3;
            end
            grd_pkg::VOP_EVEN_FIRST:
            begin
                even_new = s2_h_reg << 2;
                we_even  = 1'b1;
            end
            grd_pkg::VOP_EVEN:
            begin
                acc      = even_cur + s2_h_reg;
                even_new = odd_cur + h3;
                we_even  = 1'b1;
            end
            grd_pkg::VOP_ODD:
            begin
                even_new = even_cur + h3;
                we_even  = 1'b1;
                we_odd   = 1'b1;
            end
            grd_pkg::VOP_ODD_LAST:
            begin
                acc      = even_cur + (s2_h_reg << 2);
                even_new = acc;
                we_even  = 1'b1;
            end
            default:
            begin
                we_even = 1'b0;
            end
        endcase

        we_even    = we_even && s2_ctl_reg.valid;
        we_odd     = we_odd && s2_ctl_reg.valid;
        rounded    = acc + (W'(1) << (grd_pkg::GUARD_BITS - 1));
        res_sample = rounded[W-1:grd_pkg::GUARD_BITS];
        res_valid  = s2_ctl_reg.valid && s2_ctl_reg.emit;
        res_last   = s2_ctl_reg.last;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_even_reg <= mem_even[hc_in];
            rd_odd_reg  <= mem_odd[hc_in];
            if (we_even)
                mem_even[s2_hc_reg] <= even_new;
            if (we_odd)
                mem_odd[s2_hc_reg] <= odd_new;
            s2_h_reg          <= h_in;
            s2_hc_reg         <= hc_in;
            fwd_even_addr_reg <= s2_hc_reg;
            fwd_even_data_reg <= even_new;
            fwd_odd_addr_reg  <= s2_hc_reg;
            fwd_odd_data_reg  <= odd_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctl_reg         <= grd_pkg::VCTL_IDLE;
            fwd_even_valid_reg <= 1'b0;
            fwd_odd_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            s2_ctl_reg         <= ctl_in;
            fwd_even_valid_reg <= we_even;
            fwd_odd_valid_reg  <= we_odd;
        end
    end

endmodule

`default_nettype wire

// ----- design/grd_out_buf.sv -----
// Output register with a skid stage that decouples the pipeline from the receiver.
`timescale 1ns / 1ps
`default_nettype none

module grd_out_buf
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   res_valid,
    input  wire logic [SAMPLE_BITS-1:0] res_sample,
    input  wire logic                   res_last,
    output logic                        en,
    output logic                        coarse_valid,
    input  wire logic                   coarse_stall,
    output logic [SAMPLE_BITS-1:0]      coarse_sample,
    output logic                        frame_end
);

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SAMPLE_BITS-1:0] out_sample_reg;
    logic [SAMPLE_BITS-1:0] out_sample_next;
    logic                   out_last_reg;
    logic                   out_last_next;
    logic                   skid_valid_reg;
    logic                   skid_valid_next;
    logic [SAMPLE_BITS-1:0] skid_sample_reg;
    logic [SAMPLE_BITS-1:0] skid_sample_next;
    logic                   skid_last_reg;
    logic                   skid_last_next;
    logic                   take;

    assign en            = !skid_valid_reg;
    assign take          = res_valid && en;
    assign coarse_valid  = out_valid_reg;
    assign coarse_sample = out_sample_reg;
    assign frame_end     = out_last_reg;

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_sample_next  = out_sample_reg;
        out_last_next    = out_last_reg;
        skid_valid_next  = skid_valid_reg;
        skid_sample_next = skid_sample_reg;
        skid_last_next   = skid_last_reg;
        if (!out_valid_reg || !coarse_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_sample_next = skid_sample_reg;
                out_last_next   = skid_last_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next  = take;
                out_sample_next = res_sample;
                out_last_next   = res_last;
            end
        end
        else if (take)
        begin
            skid_valid_next  = 1'b1;
            skid_sample_next = res_sample;
            skid_last_next   = res_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_sample_reg  <= out_sample_next;
        out_last_reg    <= out_last_next;
        skid_sample_reg <= skid_sample_next;
        skid_last_reg   <= skid_last_next;
    end

endmodule

`default_nettype wire

// ----- design/grid_restrict_downsample_2d.sv -----
// Top level of the streaming 2:1 two-dimensional grid restriction block.
//
// Fine samples enter in raster order on the fine channel (fine_valid, fine_stall);
// frame_start marks fine position (0,0) and is optional after a complete frame.
// Coarse samples leave on the coarse channel (coarse_valid, coarse_stall), with
// frame_end set on the last coarse sample of each frame. A transaction happens at
// a rising edge where valid is high and stall is low.
// Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready
// is always high and writes belong only in idle periods.
// One fine sample is accepted every cycle while fine_stall is low. A coarse sample
// passes the s1, s2 and output registers after the fine sample that completes it
// is taken. The rate is set by the read-modify-write of the row accumulator
// memories, one access per cycle, with forwarding between back-to-back updates of
// one column. When the receiver stalls, the output register holds its sample and a
// skid stage takes one more; fine_stall then rises until the skid stage drains.
// Reset restores the register defaults and the raster position; the accumulator
// memories need no clearing pass, since every entry is written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module grid_restrict_downsample_2d
#(
    parameter int MAX_FINE_WIDTH  = 1024,
    parameter int MAX_FINE_HEIGHT = 1024,
    parameter int SAMPLE_BITS     = 16
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               fine_valid,
    output logic                                    fine_stall,
    input  wire logic [SAMPLE_BITS-1:0]             fine_sample,
    input  wire logic                               frame_start,
    output logic                                    coarse_valid,
    input  wire logic                               coarse_stall,
    output logic [SAMPLE_BITS-1:0]                  coarse_sample,
    output logic                                    frame_end,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [grd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [grd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int W  = SAMPLE_BITS + grd_pkg::GUARD_BITS;
    localparam int AW = $clog2(MAX_FINE_WIDTH / 2 + 1);

    grd_pkg::cfg_regs_t     cfg;
    grd_pkg::vctl_t         s1_ctl;
    logic [W-1:0]           s1_h;
    logic [AW-1:0]          s1_hc;
    logic                   en;
    logic                   res_valid;
    logic [SAMPLE_BITS-1:0] res_sample;
    logic                   res_last;

    assign fine_stall = !en;

    grd_config u_config
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    grd_col_pass
    #(
        .MAX_FINE_WIDTH  (MAX_FINE_WIDTH),
        .MAX_FINE_HEIGHT (MAX_FINE_HEIGHT),
        .SAMPLE_BITS     (SAMPLE_BITS)
    )
    u_col_pass
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .fine_valid  (fine_valid),
        .fine_sample (fine_sample),
        .frame_start (frame_start),
        .en          (en),
        .ctl_out     (s1_ctl),
        .h_out       (s1_h),
        .hc_out      (s1_hc)
    );

    grd_row_pass
    #(
        .MAX_FINE_WIDTH (MAX_FINE_WIDTH),
        .SAMPLE_BITS    (SAMPLE_BITS)
    )
    u_row_pass
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .ctl_in     (s1_ctl),
        .h_in       (s1_h),
        .hc_in      (s1_hc),
        .res_valid  (res_valid),
        .res_sample (res_sample),
        .res_last   (res_last)
    );

    grd_out_buf
    #(
        .SAMPLE_BITS (SAMPLE_BITS)
    )
    u_out_buf
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res_sample    (res_sample),
        .res_last      (res_last),
        .en            (en),
        .coarse_valid  (coarse_valid),
        .coarse_stall  (coarse_stall),
        .coarse_sample (coarse_sample),
        .frame_end     (frame_end)
    );

endmodule

`default_nettype wire

// ----- tb/tb_grid_restrict_downsample_2d.sv -----
// Self-checking testbench for the 2:1 grid restriction block with a built-in predictor.
`timescale 1ns / 1ps

module tb_grid_restrict_downsample_2d;

    localparam int MAX_FINE_WIDTH  = 1024;
    localparam int MAX_FINE_HEIGHT = 1024;
    localparam int SAMPLE_BITS     = 16;
    localparam int ACC_DEPTH       = MAX_FINE_WIDTH / 2 + 1;
    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 6;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 20;
    localparam int RANDOM_ITEMS    = 1850;
    localparam int CALM_ITEMS      = 150;
    localparam int CYCLE_LIMIT     = 500000;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   last;
    } coarse_item_t;

    typedef struct packed {
        bit                                 is_cfg;
        logic [grd_pkg::CFG_INDEX_BITS-1:0] index;
        logic [grd_pkg::CFG_DATA_BITS-1:0]  data;
        logic [SAMPLE_BITS-1:0]             value;
        logic                               start;
        bit                                 typed;
        bit                                 present;
        coarse_item_t                       want;
    } directed_step_t;

    logic                               clk           = 1'b0;
    logic                               rst_n         = 1'b0;
    logic                               fine_valid    = 1'b0;
    logic                               fine_stall;
    logic [SAMPLE_BITS-1:0]             fine_sample   = '0;
    logic                               frame_start   = 1'b0;
    logic                               coarse_valid;
    logic                               coarse_stall  = 1'b0;
    logic [SAMPLE_BITS-1:0]             coarse_sample;
    logic                               frame_end;
    logic                               cfg_valid     = 1'b0;
    logic                               cfg_ready;
    logic [grd_pkg::CFG_INDEX_BITS-1:0] cfg_index     = '0;
    logic [grd_pkg::CFG_DATA_BITS-1:0]  cfg_data      = '0;

    // Register copy and raster state of the predictor.
    logic [grd_pkg::FINE_CFG_BITS-1:0]   reg_fine_width    = grd_pkg::FINE_SIZE_RESET;
    logic [grd_pkg::FINE_CFG_BITS-1:0]   reg_fine_height   = grd_pkg::FINE_SIZE_RESET;
    logic [grd_pkg::COARSE_CFG_BITS-1:0] reg_coarse_width  = grd_pkg::COARSE_SIZE_RESET;
    logic [grd_pkg::COARSE_CFG_BITS-1:0] reg_coarse_height = grd_pkg::COARSE_SIZE_RESET;
    longint row_sum_even [ACC_DEPTH];
    longint row_sum_odd  [ACC_DEPTH];
    longint col_sum  = 0;
    longint col_head = 0;
    int     fine_x   = 0;
    int     fine_y   = 0;

    coarse_item_t   pending_coarse [$];
    directed_step_t directed_steps [$];
    coarse_item_t   want;
    int  errors      = 0;
    int  cycle_count = 0;
    int  items_sent  = 0;
    int  idle_rate   = 0;
    int  stall_rate  = 0;
    int  stall_left  = 0;
    bit  calm        = 1'b0;

    grid_restrict_downsample_2d
    #(
        .MAX_FINE_WIDTH  (MAX_FINE_WIDTH),
        .MAX_FINE_HEIGHT (MAX_FINE_HEIGHT),
        .SAMPLE_BITS     (SAMPLE_BITS)
    )
    dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .fine_valid    (fine_valid),
        .fine_stall    (fine_stall),
        .fine_sample   (fine_sample),
        .frame_start   (frame_start),
        .coarse_valid  (coarse_valid),
        .coarse_stall  (coarse_stall),
        .coarse_sample (coarse_sample),
        .frame_end     (frame_end),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    function automatic int eff_fine(input int raw, input int max_size);
        if (raw == 0)
        begin
            return 1;
        end
        return (raw > max_size) ? max_size : raw;
    endfunction

    function automatic int eff_coarse(input int raw, input int fine, output bit centered);
        int c;
        c = (raw == 0) ? 1 : raw;
        centered = (fine == 2 * c);
        if (!centered && c > (fine + 1) / 2)
        begin
            c = (fine + 1) / 2;
        end
        return c;
    endfunction

    task automatic restrict_step(input logic [SAMPLE_BITS-1:0] value, input logic start,
                                 output bit emit, output coarse_item_t result);
        int     fw, fh, cw, ch, i, j, hc, oc, orow;
        bit     hcen, vcen, have_h;
        longint s, h, acc, rounded;
        fw = eff_fine(int'(reg_fine_width), MAX_FINE_WIDTH);
        fh = eff_fine(int'(reg_fine_height), MAX_FINE_HEIGHT);
        cw = eff_coarse(int'(reg_coarse_width), fw, hcen);
        ch = eff_coarse(int'(reg_coarse_height), fh, vcen);
        s = longint'($signed(value));
        emit = 1'b0;
        have_h = 1'b0;
        h = 0;
        acc = 0;
        hc = 0;
        oc = 0;
        orow = 0;
        result = '0;
        if (start)
        begin
            fine_x = 0;
            fine_y = 0;
        end
        if (fine_x >= fw)
        begin
            fine_x = 0;
            fine_y++;
        end
        if (fine_y >= fh)
        begin
            fine_y = 0;
        end

        // Horizontal pass in eighths.
        i = fine_x / 2;
        if (hcen)
        begin
            if (fine_x % 2 == 0)
            begin
                if (i > 0)
                begin
                    col_sum += s;
                    h = col_sum;
                    hc = i - 1;
                    have_h = 1'b1;
                end
                col_sum = (i == 0) ? 4 * s : col_head + 3 * s;
                col_head = 0;
            end
            else
            begin
                col_sum += 3 * s;
                if (i + 1 < cw)
                begin
                    col_head = s;
                end
                else
                begin
                    col_sum += s;
                    h = col_sum;
                    hc = i;
                    have_h = 1'b1;
                end
            end
        end
        else if (fine_x % 2 == 0 && i < cw)
        begin
            h = 8 * s;
            hc = i;
            have_h = 1'b1;
        end

        // Vertical pass in sixty-fourths.
        if (have_h && hc < ACC_DEPTH)
        begin
            j = fine_y / 2;
            if (vcen)
            begin
                if (fine_y % 2 == 0)
                begin
                    if (j > 0)
                    begin
                        row_sum_even[hc] += h;
                        acc = row_sum_even[hc];
                        oc = hc;
                        orow = j - 1;
                        emit = 1'b1;
                    end
                    row_sum_even[hc] = (j == 0) ? 4 * h : row_sum_odd[hc] + 3 * h;
                end
                else
                begin
                    row_sum_even[hc] += 3 * h;
                    if (j + 1 < ch)
                    begin
                        row_sum_odd[hc] = h;
                    end
                    else
                    begin
                        row_sum_even[hc] += h;
                        acc = row_sum_even[hc];
                        oc = hc;
                        orow = j;
                        emit = 1'b1;
                    end
                end
            end
            else if (fine_y % 2 == 0 && j < ch)
            begin
                acc = 8 * h;
                oc = hc;
                orow = j;
                emit = 1'b1;
            end
        end

        fine_x++;
        if (fine_x >= fw)
        begin
            fine_x = 0;
            fine_y++;
            if (fine_y >= fh)
            begin
                fine_y = 0;
            end
        end

        rounded = (acc + 32) >>> 6;
        result.sample = rounded[SAMPLE_BITS-1:0];
        result.last = (oc == cw - 1 && orow == ch - 1);
    endtask

    function automatic directed_step_t cfg_step(
        input logic [grd_pkg::CFG_INDEX_BITS-1:0] index, input int data);
        directed_step_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.index = index;
        row.data = data[grd_pkg::CFG_DATA_BITS-1:0];
        return row;
    endfunction

    function automatic directed_step_t sample_step(input logic [SAMPLE_BITS-1:0] value,
                                                   input logic start, input bit typed,
                                                   input bit present,
                                                   input logic [SAMPLE_BITS-1:0] want_sample,
                                                   input logic want_last);
        directed_step_t row;
        row = '0;
        row.value = value;
        row.start = start;
        row.typed = typed;
        row.present = present;
        row.want.sample = want_sample;
        row.want.last = want_last;
        return row;
    endfunction

    function automatic void add_step(input directed_step_t step);
        directed_steps.insert(directed_steps.size(), step);
    endfunction

    // Register writes wait until the block has drained all outstanding work.
    task automatic write_reg(input logic [grd_pkg::CFG_INDEX_BITS-1:0] index, input int data);
        fine_valid <= 1'b0;
        while (pending_coarse.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data[grd_pkg::CFG_DATA_BITS-1:0];
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        case (index)
            grd_pkg::REG_FINE_WIDTH:
                reg_fine_width = data[grd_pkg::FINE_CFG_BITS-1:0];
            grd_pkg::REG_FINE_HEIGHT:
                reg_fine_height = data[grd_pkg::FINE_CFG_BITS-1:0];
            grd_pkg::REG_COARSE_WIDTH:
                reg_coarse_width = data[grd_pkg::COARSE_CFG_BITS-1:0];
            grd_pkg::REG_COARSE_HEIGHT:
                reg_coarse_height = data[grd_pkg::COARSE_CFG_BITS-1:0];
            default:
                ;
        endcase
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value, input logic start,
                               input bit typed, input bit present, input coarse_item_t typed_item);
        bit           emit;
        coarse_item_t predicted;
        if (!calm && idle_rate != 0 && $urandom_range(0, 99) < idle_rate)
        begin
            fine_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        fine_valid <= 1'b1;
        fine_sample <= value;
        frame_start <= start;
        @(posedge clk);
        while (fine_stall)
        begin
            @(posedge clk);
        end
        restrict_step(value, start, emit, predicted);
        if (typed)
        begin
            if (present)
            begin
                pending_coarse.insert(pending_coarse.size(), typed_item);
            end
        end
        else if (emit)
        begin
            pending_coarse.insert(pending_coarse.size(), predicted);
        end
        items_sent++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && coarse_valid && !coarse_stall)
        begin
            if (pending_coarse.size() == 0)
            begin
                $error("unexpected coarse transaction: coarse_sample %0d, frame_end %0b",
                       $signed(coarse_sample), frame_end);
                errors++;
            end
            else
            begin
                want = pending_coarse.pop_front();
                if (coarse_sample !== want.sample)
                begin
                    $error("coarse_sample: expected %0d, actual %0d",
                           $signed(want.sample), $signed(coarse_sample));
                    errors++;
                end
                if (frame_end !== want.last)
                begin
                    $error("frame_end: expected %0b, actual %0b", want.last, frame_end);
                    errors++;
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            coarse_stall <= 1'b1;
        end
        else if (!calm && stall_rate != 0 && $urandom_range(0, 99) < stall_rate)
        begin
            stall_left = $urandom_range(0, 15);
            coarse_stall <= 1'b1;
        end
        else
        begin
            coarse_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int                     kind, fw_raw, fh_raw, cw_raw, ch_raw, fw, fh, frame, nitems;
        int                     cap, col, row, total_items;
        bit                     hcen, vcen, at_origin;
        logic [SAMPLE_BITS-1:0] value;
        logic                   start;

        // After reset both axes are centered, so the first samples complete nothing.
        add_step(sample_step(16'h1111, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0));
        add_step(sample_step(16'h2222, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0));
        // A one-sample frame passes each sample through unchanged.
        add_step(cfg_step(grd_pkg::REG_FINE_WIDTH, 1));
        add_step(cfg_step(grd_pkg::REG_FINE_HEIGHT, 1));
        add_step(cfg_step(grd_pkg::REG_COARSE_WIDTH, 1));
        add_step(cfg_step(grd_pkg::REG_COARSE_HEIGHT, 1));
        add_step(sample_step(16'h7FFF, 1'b1, 1'b1, 1'b1, 16'h7FFF, 1'b1));
        add_step(sample_step(16'h8000, 1'b0, 1'b1, 1'b1, 16'h8000, 1'b1));
        add_step(sample_step(16'h0000, 1'b1, 1'b1, 1'b1, 16'h0000, 1'b1));
        // Zero sizes act as one.
        add_step(cfg_step(grd_pkg::REG_FINE_WIDTH, 0));
        add_step(cfg_step(grd_pkg::REG_FINE_HEIGHT, 0));
        add_step(cfg_step(grd_pkg::REG_COARSE_WIDTH, 0));
        add_step(cfg_step(grd_pkg::REG_COARSE_HEIGHT, 0));
        add_step(sample_step(16'h1234, 1'b0, 1'b1, 1'b1, 16'h1234, 1'b1));
        // A 2x2 centered frame averages four samples, rounding half up.
        add_step(cfg_step(grd_pkg::REG_FINE_WIDTH, 2));
        add_step(cfg_step(grd_pkg::REG_FINE_HEIGHT, 2));
        add_step(cfg_step(grd_pkg::REG_COARSE_WIDTH, 1));
        add_step(cfg_step(grd_pkg::REG_COARSE_HEIGHT, 1));
        add_step(sample_step(16'h0002, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0));
        add_step(sample_step(16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0));
        add_step(sample_step(16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0));
        add_step(sample_step(16'h0000, 1'b0, 1'b1, 1'b1, 16'h0001, 1'b1));
        add_step(sample_step(16'hFFFE, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0));
        add_step(sample_step(16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0));
        add_step(sample_step(16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0));
        add_step(sample_step(16'h0000, 1'b0, 1'b1, 1'b1, 16'h0000, 1'b1));
        // Oversized fine width clamps to the maximum; the staggered coarse row shrinks.
        add_step(cfg_step(grd_pkg::REG_FINE_WIDTH, 2047));
        add_step(cfg_step(grd_pkg::REG_FINE_HEIGHT, 1));
        add_step(cfg_step(grd_pkg::REG_COARSE_WIDTH, 513));
        add_step(cfg_step(grd_pkg::REG_COARSE_HEIGHT, 1));
        add_step(sample_step(16'h7FFF, 1'b1, 1'b1, 1'b1, 16'h7FFF, 1'b0));
        add_step(sample_step(16'h0001, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0));
        add_step(sample_step(16'h8000, 1'b0, 1'b1, 1'b1, 16'h8000, 1'b0));
        add_step(cfg_step(grd_pkg::REG_FINE_WIDTH, 6));
        add_step(cfg_step(grd_pkg::REG_FINE_HEIGHT, 4));
        add_step(cfg_step(grd_pkg::REG_COARSE_WIDTH, 3));
        add_step(cfg_step(grd_pkg::REG_COARSE_HEIGHT, 2));
        add_step(sample_step(16'h0100, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0));
        add_step(sample_step(16'hFF00, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0));
        add_step(sample_step(16'h0080, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0));
        add_step(sample_step(16'h7FFF, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_rate = 25;
        stall_rate = 25;
        foreach (directed_steps[k])
        begin
            if (directed_steps[k].is_cfg)
            begin
                write_reg(directed_steps[k].index, int'(directed_steps[k].data));
            end
            else
            begin
                send_sample(directed_steps[k].value, directed_steps[k].start,
                            directed_steps[k].typed, directed_steps[k].present,
                            directed_steps[k].want);
            end
        end

        total_items = items_sent + RANDOM_ITEMS;
        while (items_sent < total_items)
        begin
            kind = $urandom_range(0, 19);
            if (kind == 0)
            begin
                fw_raw = $urandom_range(1000, 2047);
                fh_raw = $urandom_range(1, 3);
                cw_raw = $urandom_range(0, 1) ? 512 : $urandom_range(0, 1023);
                ch_raw = $urandom_range(0, 2);
                cap = 160;
            end
            else
            begin
                fw_raw = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
                fh_raw = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: cw_raw = fw_raw / 2;
                    6, 7, 8:          cw_raw = $urandom_range(0, 8);
                    default:          cw_raw = $urandom_range(0, 1023);
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: ch_raw = fh_raw / 2;
                    6, 7, 8:          ch_raw = $urandom_range(0, 8);
                    default:          ch_raw = $urandom_range(0, 1023);
                endcase
                cap = 240;
            end
            write_reg(grd_pkg::REG_FINE_WIDTH, fw_raw);
            write_reg(grd_pkg::REG_FINE_HEIGHT, fh_raw);
            write_reg(grd_pkg::REG_COARSE_WIDTH, cw_raw + 1024 * $urandom_range(0, 1));
            write_reg(grd_pkg::REG_COARSE_HEIGHT, ch_raw + 1024 * $urandom_range(0, 1));

            fw = eff_fine(fw_raw, MAX_FINE_WIDTH);
            fh = eff_fine(fh_raw, MAX_FINE_HEIGHT);
            void'(eff_coarse(cw_raw, fw, hcen));
            void'(eff_coarse(ch_raw, fh, vcen));
            frame = fw * fh;
            if ($urandom_range(0, 3) == 0)
            begin
                nitems = $urandom_range(1, 2 * frame);
            end
            else
            begin
                nitems = frame * $urandom_range(1, 3);
            end
            if (nitems > cap)
            begin
                nitems = cap;
            end
            if (nitems > total_items - items_sent)
            begin
                nitems = total_items - items_sent;
            end
            case ($urandom_range(0, 2))
                0:       idle_rate = 0;
                1:       idle_rate = 10;
                default: idle_rate = 35;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_rate = 0;
                1:       stall_rate = 10;
                default: stall_rate = 35;
            endcase

            // A vertically centered phase always opens a fresh frame, so every
            // accumulator entry is written before it is read.
            for (int n = 0; n < nitems; n++)
            begin
                col = fine_x;
                row = fine_y;
                if (col >= fw)
                begin
                    col = 0;
                    row++;
                end
                if (row >= fh)
                begin
                    row = 0;
                end
                at_origin = (col == 0 && row == 0);
                if (n == 0 && vcen)
                begin
                    start = 1'b1;
                end
                else if (at_origin)
                begin
                    start = 1'($urandom_range(0, 1));
                end
                else if (!vcen && $urandom_range(0, 39) == 0)
                begin
                    start = 1'b1;
                end
                else
                begin
                    start = 1'b0;
                end
                case ($urandom_range(0, 9))
                    0:       value = 16'h7FFF;
                    1:       value = 16'h8000;
                    2:       value = SAMPLE_BITS'($urandom_range(0, 15) - 8);
                    default: value = SAMPLE_BITS'($urandom);
                endcase
                if (items_sent >= total_items - CALM_ITEMS)
                begin
                    calm = 1'b1;
                end
                send_sample(value, start, 1'b0, 1'b0, '0);
            end
        end

        fine_valid <= 1'b0;
        while (pending_coarse.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/grd_pkg.sv
design/grd_config.sv
design/grd_col_pass.sv
design/grd_row_pass.sv
design/grd_out_buf.sv
design/grid_restrict_downsample_2d.sv
tb/tb_grid_restrict_downsample_2d.sv
